[sv/ycc2rgb_pkg.sv]
// shared types, register codes and fixed-point constants for the ycbcr to rgb converter
`timescale 1ns / 1ps

package ycc2rgb_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W = 16;
    localparam int Q16_W = SAMPLE_W + FRAC_W;
    localparam int COEF_W = 18;
    localparam int CFG_INDEX_W = 3;
    localparam int DATA_W = 3 * SAMPLE_W;

    localparam logic [1:0] MODE_COPY = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_NOMINAL = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NARROW_OUTPUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CR_TO_R = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CB_TO_G = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CR_TO_G = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CB_TO_B = 3'd5;

    localparam logic [1:0] MODE_RESET = MODE_FULL;
    localparam logic NARROW_RESET = 1'b0;
    localparam logic [COEF_W-1:0] COEF_CR_TO_R_RESET = 18'd91881;
    localparam logic [COEF_W-1:0] COEF_CB_TO_G_RESET = 18'd22554;
    localparam logic [COEF_W-1:0] COEF_CR_TO_G_RESET = 18'd46802;
    localparam logic [COEF_W-1:0] COEF_CB_TO_B_RESET = 18'd116130;

    // studio range stretch: luma * 255 / 219, chroma * 255 * 2048 / 7
    localparam int STRETCH_NUM = 255;
    localparam int LUMA_DIV = 219;
    localparam int CHROMA_DIV = 7;
    localparam int CHROMA_FRAC_W = 11;

    localparam int LUMA_N_W = 24;
    localparam int LUMA_MAGIC_W = 25;
    localparam int LUMA_SHIFT = 32;
    localparam int LUMA_A_W = 17;
    localparam int LUMA_B_W = 8;
    localparam logic [LUMA_MAGIC_W-1:0] LUMA_MAGIC = 25'd19611723;

    localparam int CHROMA_M_W = 23;
    localparam int CHROMA_MAGIC_W = 24;
    localparam int CHROMA_SHIFT = 26;
    localparam int CHROMA_A_W = 21;
    localparam int CHROMA_B_W = 3;
    localparam logic [CHROMA_MAGIC_W-1:0] CHROMA_MAGIC = 24'd9586981;

    localparam int PROD_W = COEF_W + 1 + Q16_W;
    localparam int ACC_W = PROD_W + 1;
    localparam int ACC_INT_W = ACC_W - 2 * FRAC_W;

    typedef logic [(1 << LUMA_B_W)-1:0][FRAC_W-1:0] luma_frac_t;
    typedef logic [(1 << CHROMA_B_W)-1:0][CHROMA_FRAC_W-1:0] chroma_frac_t;

    function automatic luma_frac_t build_luma_frac();
        luma_frac_t t;
        for (int i = 0; i < (1 << LUMA_B_W); i++)
        begin
            t[i] = FRAC_W'((i << FRAC_W) / LUMA_DIV);
        end
        return t;
    endfunction

    function automatic chroma_frac_t build_chroma_frac();
        chroma_frac_t t;
        for (int i = 0; i < (1 << CHROMA_B_W); i++)
        begin
            t[i] = CHROMA_FRAC_W'((i << CHROMA_FRAC_W) / CHROMA_DIV);
        end
        return t;
    endfunction

    localparam luma_frac_t LUMA_FRAC = build_luma_frac();
    localparam chroma_frac_t CHROMA_FRAC = build_chroma_frac();

    typedef struct packed {
        logic [1:0]        mode;
        logic              narrow_output;
        logic [COEF_W-1:0] coef_cr_to_r;
        logic [COEF_W-1:0] coef_cb_to_g;
        logic [COEF_W-1:0] coef_cr_to_g;
        logic [COEF_W-1:0] coef_cb_to_b;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]     y;
        logic [SAMPLE_W-1:0]     cb;
        logic [SAMPLE_W-1:0]     cr;
        logic [Q16_W-1:0]        y16;
        logic signed [Q16_W-1:0] dcb;
        logic signed [Q16_W-1:0] dcr;
    } mtx_in_t;

endpackage

[sv/ycc2rgb_front.sv]
// input stages: sample masking, studio range stretch and q16 operand selection
`timescale 1ns / 1ps

module ycc2rgb_front
    import ycc2rgb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_luma,
    input  logic [SAMPLE_W-1:0] in_cb,
    input  logic [SAMPLE_W-1:0] in_cr,
    output logic                out_valid,
    input  logic                out_ready,
    output mtx_in_t             out_data
);

    localparam logic [SAMPLE_W-1:0] SMAX = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [SAMPLE_W-1:0] SMID = SAMPLE_W'(1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_W-1:0] SBLACK = SAMPLE_W'(16 << (SAMPLE_BITS - 8));
    localparam logic [Q16_W-1:0] LUMA_SAT = {SMAX, {FRAC_W{1'b0}}};
    localparam logic [Q16_W-1:0] CHROMA_NEG_LIM = {SMID, {FRAC_W{1'b0}}};
    localparam logic [Q16_W-1:0] CHROMA_POS_LIM = {SMAX - SMID, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                neg_cb;
        logic                neg_cr;
    } raw_t;

    logic en1, en2, en3, en4;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    raw_t s1_raw_reg, s2_raw_reg, s3_raw_reg;
    raw_t s1_raw_next;

    logic [LUMA_N_W-1:0]   s1_n_reg, s2_n_reg;
    logic [CHROMA_M_W-1:0] s1_mcb_reg, s1_mcr_reg, s2_mcb_reg, s2_mcr_reg;
    logic [LUMA_N_W-1:0]   s1_n_next;
    logic [CHROMA_M_W-1:0] s1_mcb_next, s1_mcr_next;

    logic [LUMA_A_W-1:0]   s2_ay_reg, s3_ay_reg;
    logic [CHROMA_A_W-1:0] s2_acb_reg, s2_acr_reg, s3_acb_reg, s3_acr_reg;
    logic [LUMA_A_W-1:0]   s2_ay_next;
    logic [CHROMA_A_W-1:0] s2_acb_next, s2_acr_next;

    logic [LUMA_B_W-1:0]   s3_by_reg, s3_by_next;
    logic [CHROMA_B_W-1:0] s3_bcb_reg, s3_bcr_reg, s3_bcb_next, s3_bcr_next;

    mtx_in_t out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0] yoff, mag_cb, mag_cr;

    logic [LUMA_N_W+LUMA_MAGIC_W-1:0]     y_prod;
    logic [CHROMA_M_W+CHROMA_MAGIC_W-1:0] cb_prod, cr_prod;

    logic [LUMA_N_W-1:0]   y_rem;
    logic [CHROMA_M_W-1:0] cb_rem, cr_rem;

    logic [LUMA_A_W+FRAC_W-1:0] y16_wide;
    logic [Q16_W-1:0]           y16_nom, q_cb, q_cr, qs_cb, qs_cr;
    logic signed [Q16_W-1:0]    d_cb_nom, d_cr_nom;
    logic signed [SAMPLE_W:0]   diff_cb, diff_cr;
    logic [SAMPLE_W+FRAC_W:0]   full_cb, full_cr;

    assign en4 = !s4_valid_reg || out_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign out_valid = s4_valid_reg;
    assign out_data = out_data_reg;

    // stage 1: mask, offsets and x255
    always_comb
    begin
        s1_raw_next.y = in_luma & SMAX;
        s1_raw_next.cb = in_cb & SMAX;
        s1_raw_next.cr = in_cr & SMAX;
        s1_raw_next.neg_cb = s1_raw_next.cb < SMID;
        s1_raw_next.neg_cr = s1_raw_next.cr < SMID;
        yoff = (s1_raw_next.y >= SBLACK) ? s1_raw_next.y - SBLACK : '0;
        mag_cb = s1_raw_next.neg_cb ? SMID - s1_raw_next.cb : s1_raw_next.cb - SMID;
        mag_cr = s1_raw_next.neg_cr ? SMID - s1_raw_next.cr : s1_raw_next.cr - SMID;
        s1_n_next = LUMA_N_W'(yoff) * LUMA_N_W'(STRETCH_NUM);
        s1_mcb_next = CHROMA_M_W'(mag_cb) * CHROMA_M_W'(STRETCH_NUM);
        s1_mcr_next = CHROMA_M_W'(mag_cr) * CHROMA_M_W'(STRETCH_NUM);
    end

    // stage 2: quotient by reciprocal multiply
    always_comb
    begin
        y_prod = (LUMA_N_W + LUMA_MAGIC_W)'(s1_n_reg) * (LUMA_N_W + LUMA_MAGIC_W)'(LUMA_MAGIC);
        cb_prod = (CHROMA_M_W + CHROMA_MAGIC_W)'(s1_mcb_reg)
            * (CHROMA_M_W + CHROMA_MAGIC_W)'(CHROMA_MAGIC);
        cr_prod = (CHROMA_M_W + CHROMA_MAGIC_W)'(s1_mcr_reg)
            * (CHROMA_M_W + CHROMA_MAGIC_W)'(CHROMA_MAGIC);
        s2_ay_next = y_prod[LUMA_SHIFT +: LUMA_A_W];
        s2_acb_next = cb_prod[CHROMA_SHIFT +: CHROMA_A_W];
        s2_acr_next = cr_prod[CHROMA_SHIFT +: CHROMA_A_W];
    end

    // stage 3: remainders
    always_comb
    begin
        y_rem = s2_n_reg - LUMA_N_W'(s2_ay_reg) * LUMA_N_W'(LUMA_DIV);
        cb_rem = s2_mcb_reg - CHROMA_M_W'(s2_acb_reg) * CHROMA_M_W'(CHROMA_DIV);
        cr_rem = s2_mcr_reg - CHROMA_M_W'(s2_acr_reg) * CHROMA_M_W'(CHROMA_DIV);
        s3_by_next = y_rem[LUMA_B_W-1:0];
        s3_bcb_next = cb_rem[CHROMA_B_W-1:0];
        s3_bcr_next = cr_rem[CHROMA_B_W-1:0];
    end

    // stage 4: fraction tables, saturation and mode select
    always_comb
    begin
        y16_wide = {s3_ay_reg, LUMA_FRAC[s3_by_reg]};
        y16_nom = (y16_wide > (LUMA_A_W + FRAC_W)'(LUMA_SAT)) ? LUMA_SAT : y16_wide[Q16_W-1:0];
        q_cb = {s3_acb_reg, CHROMA_FRAC[s3_bcb_reg]};
        q_cr = {s3_acr_reg, CHROMA_FRAC[s3_bcr_reg]};
        if (s3_raw_reg.neg_cb)
        begin
            qs_cb = (q_cb > CHROMA_NEG_LIM) ? CHROMA_NEG_LIM : q_cb;
        end
        else
        begin
            qs_cb = (q_cb > CHROMA_POS_LIM) ? CHROMA_POS_LIM : q_cb;
        end
        if (s3_raw_reg.neg_cr)
        begin
            qs_cr = (q_cr > CHROMA_NEG_LIM) ? CHROMA_NEG_LIM : q_cr;
        end
        else
        begin
            qs_cr = (q_cr > CHROMA_POS_LIM) ? CHROMA_POS_LIM : q_cr;
        end
        d_cb_nom = s3_raw_reg.neg_cb ? $signed(Q16_W'(0) - qs_cb) : $signed(qs_cb);
        d_cr_nom = s3_raw_reg.neg_cr ? $signed(Q16_W'(0) - qs_cr) : $signed(qs_cr);
        diff_cb = $signed({1'b0, s3_raw_reg.cb}) - $signed({1'b0, SMID});
        diff_cr = $signed({1'b0, s3_raw_reg.cr}) - $signed({1'b0, SMID});
        full_cb = {diff_cb, {FRAC_W{1'b0}}};
        full_cr = {diff_cr, {FRAC_W{1'b0}}};

        out_data_next.y = s3_raw_reg.y;
        out_data_next.cb = s3_raw_reg.cb;
        out_data_next.cr = s3_raw_reg.cr;
        if (cfg.mode == MODE_NOMINAL)
        begin
            out_data_next.y16 = y16_nom;
            out_data_next.dcb = d_cb_nom;
            out_data_next.dcr = d_cr_nom;
        end
        else
        begin
            out_data_next.y16 = {s3_raw_reg.y, {FRAC_W{1'b0}}};
            out_data_next.dcb = $signed(full_cb[Q16_W-1:0]);
            out_data_next.dcr = $signed(full_cr[Q16_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_raw_reg <= s1_raw_next;
            s1_n_reg <= s1_n_next;
            s1_mcb_reg <= s1_mcb_next;
            s1_mcr_reg <= s1_mcr_next;
        end
        if (en2)
        begin
            s2_raw_reg <= s1_raw_reg;
            s2_n_reg <= s1_n_reg;
            s2_mcb_reg <= s1_mcb_reg;
            s2_mcr_reg <= s1_mcr_reg;
            s2_ay_reg <= s2_ay_next;
            s2_acb_reg <= s2_acb_next;
            s2_acr_reg <= s2_acr_next;
        end
        if (en3)
        begin
            s3_raw_reg <= s2_raw_reg;
            s3_ay_reg <= s2_ay_reg;
            s3_acb_reg <= s2_acb_reg;
            s3_acr_reg <= s2_acr_reg;
            s3_by_reg <= s3_by_next;
            s3_bcb_reg <= s3_bcb_next;
            s3_bcr_reg <= s3_bcr_next;
        end
        if (en4)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[sv/ycbcr_to_rgb_converter_core.sv]
// top level of the ycbcr to rgb converter: config registers, matrix stages and output register
`timescale 1ns / 1ps

// Converts one Y/Cb/Cr pixel per clock, while m_axis_tready stays high, into R/G/B (or
// passes it through in copy mode); each accepted input word becomes one output word.
// The data path is a seven-stage pipeline: masking and x255, reciprocal multiply for the
// studio range stretch, remainder, fraction table and saturation, the four coefficient
// multipliers, the channel sums, and clamping into the output register. Every stage has
// its own valid bit and takes a new word whenever it is empty or its successor moves, so
// the sustained rate is one pixel per cycle while m_axis_tready stays high, and bubbles
// close up behind a stalled output. The user must write configuration through cfg_wr_en
// while no pixel is in flight; the block does not check it. Indexes 6 and 7 are ignored.
module ycbcr_to_rgb_converter_core
    import ycc2rgb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,  // luma, chroma_blue, chroma_red
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,  // red_or_first, green_or_second, blue_or_third
    output logic                   m_axis_tuser,  // is_rgb
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam logic [SAMPLE_W-1:0] SMAX = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam int NARROW_SHIFT = SAMPLE_BITS - 8;

    logic [1:0]        mode_reg;
    logic              narrow_output_reg;
    logic [COEF_W-1:0] coef_cr_to_r_reg, coef_cb_to_g_reg, coef_cr_to_g_reg, coef_cb_to_b_reg;
    cfg_t              cfg;

    logic    front_valid, front_ready;
    mtx_in_t front_data;

    logic en5, en6, en7;
    logic s5_valid_reg, s6_valid_reg, out_valid_reg;

    logic [DATA_W-1:0]        s5_copy_reg, s6_copy_reg;
    logic [Q16_W-1:0]         s5_y16_reg;
    logic signed [PROD_W-1:0] s5_pr_reg, s5_pgb_reg, s5_pgr_reg, s5_pbb_reg;
    logic signed [PROD_W-1:0] s5_pr_next, s5_pgb_next, s5_pgr_next, s5_pbb_next;

    logic signed [ACC_W-1:0] s6_acc_r_reg, s6_acc_g_reg, s6_acc_b_reg;
    logic signed [ACC_W-1:0] s6_acc_r_next, s6_acc_g_next, s6_acc_b_next;
    logic signed [ACC_W-1:0] y32;

    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;
    logic [SAMPLE_W-1:0] ch_r, ch_g, ch_b;

    function automatic logic [SAMPLE_W-1:0] finish_ch(input logic signed [ACC_W-1:0] acc);
        logic [ACC_INT_W-1:0] v;
        v = acc[ACC_W-1:2*FRAC_W];
        priority if (acc[ACC_W-1])
        begin
            return '0;
        end
        else if (v > ACC_INT_W'(SMAX))
        begin
            return SMAX;
        end
        else
        begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

    assign cfg.mode = mode_reg;
    assign cfg.narrow_output = narrow_output_reg;
    assign cfg.coef_cr_to_r = coef_cr_to_r_reg;
    assign cfg.coef_cb_to_g = coef_cb_to_g_reg;
    assign cfg.coef_cr_to_g = coef_cr_to_g_reg;
    assign cfg.coef_cb_to_b = coef_cb_to_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            narrow_output_reg <= NARROW_RESET;
            coef_cr_to_r_reg <= COEF_CR_TO_R_RESET;
            coef_cb_to_g_reg <= COEF_CB_TO_G_RESET;
            coef_cr_to_g_reg <= COEF_CR_TO_G_RESET;
            coef_cb_to_b_reg <= COEF_CB_TO_B_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:          mode_reg <= cfg_data[1:0];
                REG_NARROW_OUTPUT: narrow_output_reg <= cfg_data[0];
                REG_COEF_CR_TO_R:  coef_cr_to_r_reg <= cfg_data;
                REG_COEF_CB_TO_G:  coef_cb_to_g_reg <= cfg_data;
                REG_COEF_CR_TO_G:  coef_cr_to_g_reg <= cfg_data;
                REG_COEF_CB_TO_B:  coef_cb_to_b_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    ycc2rgb_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_luma  (s_axis_tdata[SAMPLE_W-1:0]),
        .in_cb    (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .in_cr    (s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .out_valid(front_valid),
        .out_ready(front_ready),
        .out_data (front_data)
    );

    assign en7 = !out_valid_reg || m_axis_tready;
    assign en6 = !s6_valid_reg || en7;
    assign en5 = !s5_valid_reg || en6;
    assign front_ready = en5;

    // stage 5: coefficient products
    always_comb
    begin
        s5_pr_next = $signed({1'b0, coef_cr_to_r_reg}) * front_data.dcr;
        s5_pgb_next = $signed({1'b0, coef_cb_to_g_reg}) * front_data.dcb;
        s5_pgr_next = $signed({1'b0, coef_cr_to_g_reg}) * front_data.dcr;
        s5_pbb_next = $signed({1'b0, coef_cb_to_b_reg}) * front_data.dcb;
    end

    // stage 6: q32 channel sums
    always_comb
    begin
        y32 = $signed({{(ACC_W-Q16_W-FRAC_W){1'b0}}, s5_y16_reg, {FRAC_W{1'b0}}});
        s6_acc_r_next = y32 + {s5_pr_reg[PROD_W-1], s5_pr_reg};
        s6_acc_g_next = y32 - {s5_pgb_reg[PROD_W-1], s5_pgb_reg}
            - {s5_pgr_reg[PROD_W-1], s5_pgr_reg};
        s6_acc_b_next = y32 + {s5_pbb_reg[PROD_W-1], s5_pbb_reg};
    end

    // stage 7: clamp, copy select, narrow output
    always_comb
    begin
        out_user_next = (mode_reg == MODE_FULL) || (mode_reg == MODE_NOMINAL);
        if (out_user_next)
        begin
            ch_r = finish_ch(s6_acc_r_reg);
            ch_g = finish_ch(s6_acc_g_reg);
            ch_b = finish_ch(s6_acc_b_reg);
        end
        else
        begin
            ch_r = s6_copy_reg[SAMPLE_W-1:0];
            ch_g = s6_copy_reg[2*SAMPLE_W-1:SAMPLE_W];
            ch_b = s6_copy_reg[3*SAMPLE_W-1:2*SAMPLE_W];
        end
        if (narrow_output_reg)
        begin
            ch_r = ch_r >> NARROW_SHIFT;
            ch_g = ch_g >> NARROW_SHIFT;
            ch_b = ch_b >> NARROW_SHIFT;
        end
        out_data_next = {ch_b, ch_g, ch_r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en5)
            begin
                s5_valid_reg <= front_valid;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (en7)
            begin
                out_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_copy_reg <= {front_data.cr, front_data.cb, front_data.y};
            s5_y16_reg <= front_data.y16;
            s5_pr_reg <= s5_pr_next;
            s5_pgb_reg <= s5_pgb_next;
            s5_pgr_reg <= s5_pgr_next;
            s5_pbb_reg <= s5_pbb_next;
        end
        if (en6)
        begin
            s6_copy_reg <= s5_copy_reg;
            s6_acc_r_reg <= s6_acc_r_next;
            s6_acc_g_reg <= s6_acc_g_next;
            s6_acc_b_reg <= s6_acc_b_next;
        end
        if (en7)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_data))
        else $error("front stage dropped or changed a stalled word");

    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en6 |=> s6_valid_reg && $stable(s6_acc_r_reg) && $stable(s6_acc_g_reg)
            && $stable(s6_acc_b_reg))
        else $error("sum stage lost a word under stall");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !s6_valid_reg |=> !m_axis_tvalid)
        else $error("output word repeated after drain");

endmodule

[tb/ycbcr_to_rgb_converter_core_test.sv]
// self-checking testbench for the ycbcr to rgb converter core: stream stimulus and scoreboard
`timescale 1ns / 1ps

module ycbcr_to_rgb_converter_core_test;
    import ycc2rgb_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam longint SAMPLE_MAX = 65535;
    localparam longint SAMPLE_MID = 32768;
    localparam longint LUMA_BLACK = 4096;
    localparam longint Q16_ONE = 65536;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
        logic [SAMPLE_W-1:0] third;
        logic                is_rgb;
    } rgb_word_t;

    class rgb_checker;
        logic [1:0]        mode = MODE_RESET;
        logic              narrow = NARROW_RESET;
        logic [COEF_W-1:0] coef_cr_to_r = COEF_CR_TO_R_RESET;
        logic [COEF_W-1:0] coef_cb_to_g = COEF_CB_TO_G_RESET;
        logic [COEF_W-1:0] coef_cr_to_g = COEF_CR_TO_G_RESET;
        logic [COEF_W-1:0] coef_cb_to_b = COEF_CB_TO_B_RESET;
        rgb_word_t         expected_rgb[$];
        int                errors = 0;

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [COEF_W-1:0] value);
            case (index)
                REG_MODE:          mode = value[1:0];
                REG_NARROW_OUTPUT: narrow = value[0];
                REG_COEF_CR_TO_R:  coef_cr_to_r = value;
                REG_COEF_CB_TO_G:  coef_cb_to_g = value;
                REG_COEF_CR_TO_G:  coef_cr_to_g = value;
                REG_COEF_CB_TO_B:  coef_cb_to_b = value;
                default: ;
            endcase
        endfunction

        // q.32 sum to clamped sample
        function longint to_sample(longint acc);
            if (acc < 0)
                return 0;
            if ((acc >>> 32) > SAMPLE_MAX)
                return SAMPLE_MAX;
            return acc >>> 32;
        endfunction

        // studio chroma to signed q.16 offset, truncated toward zero
        function longint stretch_chroma(longint c);
            longint diff;
            longint q;
            longint d;
            diff = c - SAMPLE_MID;
            q = ((diff < 0 ? -diff : diff) * 255 * Q16_ONE) / 224;
            d = diff < 0 ? -q : q;
            if (d < -SAMPLE_MID * Q16_ONE)
                d = -SAMPLE_MID * Q16_ONE;
            if (d > (SAMPLE_MAX - SAMPLE_MID) * Q16_ONE)
                d = (SAMPLE_MAX - SAMPLE_MID) * Q16_ONE;
            return d;
        endfunction

        function longint stretch_luma(longint y);
            longint n;
            longint v;
            n = (y - LUMA_BLACK) * 255;
            if (n < 0)
                return 0;
            v = (n * Q16_ONE) / 219;
            if (v > SAMPLE_MAX * Q16_ONE)
                v = SAMPLE_MAX * Q16_ONE;
            return v;
        endfunction

        function rgb_word_t convert_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] cb,
                                          logic [SAMPLE_W-1:0] cr);
            longint    y16;
            longint    dcb;
            longint    dcr;
            longint    y32;
            longint    ch[3];
            rgb_word_t w;
            if (mode == MODE_FULL || mode == MODE_NOMINAL)
            begin
                if (mode == MODE_FULL)
                begin
                    y16 = longint'(y) * Q16_ONE;
                    dcb = (longint'(cb) - SAMPLE_MID) * Q16_ONE;
                    dcr = (longint'(cr) - SAMPLE_MID) * Q16_ONE;
                end
                else
                begin
                    y16 = stretch_luma(longint'(y));
                    dcb = stretch_chroma(longint'(cb));
                    dcr = stretch_chroma(longint'(cr));
                end
                y32 = y16 * Q16_ONE;
                ch[0] = to_sample(y32 + longint'(coef_cr_to_r) * dcr);
                ch[1] = to_sample(y32 - longint'(coef_cb_to_g) * dcb
                                      - longint'(coef_cr_to_g) * dcr);
                ch[2] = to_sample(y32 + longint'(coef_cb_to_b) * dcb);
                w.is_rgb = 1'b1;
            end
            else
            begin
                ch[0] = longint'(y);
                ch[1] = longint'(cb);
                ch[2] = longint'(cr);
                w.is_rgb = 1'b0;
            end
            if (narrow)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ch[i] = ch[i] >> (SAMPLE_W - 8);
                end
            end
            w.first = SAMPLE_W'(ch[0]);
            w.second = SAMPLE_W'(ch[1]);
            w.third = SAMPLE_W'(ch[2]);
            return w;
        endfunction

        function void note_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] cb,
                                 logic [SAMPLE_W-1:0] cr);
            expected_rgb.push_back(convert_pixel(y, cb, cr));
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_rgb(logic [DATA_W-1:0] data, logic is_rgb);
            rgb_word_t want;
            if (expected_rgb.size() == 0)
            begin
                report($sformatf("unexpected word %h, is_rgb %b", data, is_rgb));
                return;
            end
            want = expected_rgb.pop_front();
            if (data[SAMPLE_W-1:0] !== want.first)
                report($sformatf("red_or_first %h, expected %h",
                                 data[SAMPLE_W-1:0], want.first));
            if (data[2*SAMPLE_W-1:SAMPLE_W] !== want.second)
                report($sformatf("green_or_second %h, expected %h",
                                 data[2*SAMPLE_W-1:SAMPLE_W], want.second));
            if (data[3*SAMPLE_W-1:2*SAMPLE_W] !== want.third)
                report($sformatf("blue_or_third %h, expected %h",
                                 data[3*SAMPLE_W-1:2*SAMPLE_W], want.third));
            if (is_rgb !== want.is_rgb)
                report($sformatf("is_rgb %b, expected %b", is_rgb, want.is_rgb));
        endtask

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [DATA_W-1:0]      m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]      cfg_data = '0;
    int                     src_idle_pct = 0;
    int                     sink_idle_pct = 0;
    int                     cycle_count = 0;
    rgb_checker             board = new();

    ycbcr_to_rgb_converter_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ycbcr_to_rgb_converter_core_test: done, errors");
            $finish;
        end
    end

    // output side: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            board.check_rgb(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] edges[8] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                                          16'h1000, 16'h0fff, 16'heb00, 16'hf000};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 7)];
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(logic [COEF_W-1:0] nominal);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_MAX;
            2, 3, 4: return nominal;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] cb,
                              input logic [SAMPLE_W-1:0] cr);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cr, cb, y};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pixel(y, cb, cr);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [COEF_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        board.write_reg(index, value);
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [1:0] m, input logic nar,
                                  input logic [COEF_W-1:0] k_r, input logic [COEF_W-1:0] k_gb,
                                  input logic [COEF_W-1:0] k_gr, input logic [COEF_W-1:0] k_bb);
        logic [COEF_W-1:0] v;
        wait_idle();
        // unused upper bits of mode and narrow carry noise
        v = COEF_W'($urandom);
        v[1:0] = m;
        cfg_write(REG_MODE, v);
        v = COEF_W'($urandom);
        v[0] = nar;
        cfg_write(REG_NARROW_OUTPUT, v);
        cfg_write(REG_COEF_CR_TO_R, k_r);
        cfg_write(REG_COEF_CB_TO_G, k_gb);
        cfg_write(REG_COEF_CR_TO_G, k_gr);
        cfg_write(REG_COEF_CB_TO_B, k_bb);
        cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, COEF_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [1:0] seg_mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 77 : 0;
            sink_idle_pct <= (phase == 0) ? 77 : (phase == 1) ? 29 : 0;

            if (phase == 0)
            begin
                // full range with reset coefficients
                send_pixel(16'h0000, 16'h8000, 16'h8000);
                send_pixel(16'hffff, 16'h8000, 16'h8000);
                send_pixel(16'h0000, 16'h0000, 16'h0000);
                send_pixel(16'hffff, 16'hffff, 16'hffff);
                send_pixel(16'h0000, 16'hffff, 16'h0000);
                send_pixel(16'hffff, 16'h0000, 16'hffff);
                // studio range edges
                apply_settings(MODE_NOMINAL, 1'b0, COEF_CR_TO_R_RESET, COEF_CB_TO_G_RESET,
                               COEF_CR_TO_G_RESET, COEF_CB_TO_B_RESET);
                send_pixel(16'h1000, 16'h8000, 16'h8000);
                send_pixel(16'heb00, 16'h1000, 16'hf000);
                send_pixel(16'h0fff, 16'h0000, 16'hffff);
                send_pixel(16'hffff, 16'hffff, 16'h0000);
                send_pixel(16'h0000, 16'h7fff, 16'h8001);
                send_pixel(16'h1001, 16'hf001, 16'h0fff);
                // narrow copy
                apply_settings(MODE_COPY, 1'b1, COEF_CR_TO_R_RESET, COEF_CB_TO_G_RESET,
                               COEF_CR_TO_G_RESET, COEF_CB_TO_B_RESET);
                send_pixel(16'h1234, 16'habcd, 16'hff00);
                send_pixel(16'hffff, 16'h0000, 16'h00ff);
                // unused mode acts as copy
                apply_settings(MODE_SPARE, 1'b0, COEF_CR_TO_R_RESET, COEF_CB_TO_G_RESET,
                               COEF_CR_TO_G_RESET, COEF_CB_TO_B_RESET);
                send_pixel(16'hffff, 16'h0001, 16'h8000);
                send_pixel(16'h0000, 16'hfffe, 16'h7fff);
                apply_settings(MODE_FULL, 1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                send_pixel(16'hffff, 16'hffff, 16'h0000);
                send_pixel(16'h8000, 16'h0000, 16'hffff);
                send_pixel(16'h0000, 16'hffff, 16'hffff);
                apply_settings(MODE_NOMINAL, 1'b1, '0, '0, '0, '0);
                send_pixel(16'heb00, 16'hf000, 16'h1000);
                send_pixel(16'hffff, 16'h0000, 16'h0000);
            end

            for (int seg = 0; seg < 6; seg++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: seg_mode = MODE_FULL;
                    4, 5, 6, 7: seg_mode = MODE_NOMINAL;
                    8:          seg_mode = MODE_COPY;
                    default:    seg_mode = MODE_SPARE;
                endcase
                apply_settings(seg_mode, 1'($urandom_range(0, 1)),
                               pick_coef(COEF_CR_TO_R_RESET), pick_coef(COEF_CB_TO_G_RESET),
                               pick_coef(COEF_CR_TO_G_RESET), pick_coef(COEF_CB_TO_B_RESET));
                repeat (58) send_pixel(random_sample(), random_sample(), random_sample());
            end
        end

        wait_idle();
        if (board.errors == 0)
            $display("ycbcr_to_rgb_converter_core_test: done, clean");
        else
            $display("ycbcr_to_rgb_converter_core_test: done, errors");
        $finish;
    end

endmodule
